@@ hw/rtl/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the RLE sprite span decoder
// Input modes, span kinds, configuration register indexes, control byte codes
// and the parser phase encoding.
// ----------------------------------------------------------------------------
package rss_pkg;

  typedef enum logic [1:0] {
    MODE_STREAM = 2'd0,
    MODE_LOAD   = 2'd1,
    MODE_START  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_SPAN  = 2'd0,
    KIND_SHADE = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_CLIP_LEFT    = 3'd2,
    REG_CLIP_RIGHT   = 3'd3,
    REG_CLIP_TOP     = 3'd4,
    REG_CLIP_BOTTOM  = 3'd5,
    REG_MIRROR       = 3'd6,
    REG_REMAP_ENABLE = 3'd7
  } reg_index_t;

  localparam int CLIP_RIGHT_RESET  = 640;
  localparam int CLIP_BOTTOM_RESET = 480;

  localparam logic [7:0] CTRL_ROW_END    = 8'h00;
  localparam logic [7:0] CTRL_SPRITE_END = 8'h80;
  localparam logic [7:0] CTRL_SHADOW     = 8'hC0;
  localparam logic [7:0] CTRL_FILL       = 8'hC1;

  typedef enum logic [5:0] {
    PH_CTRL = 6'b000001,
    PH_LIT  = 6'b000010,
    PH_SHA  = 6'b000100,
    PH_SHB  = 6'b001000,
    PH_FCNT = 6'b010000,
    PH_FVAL = 6'b100000
  } phase_t;

endpackage

@@ hw/rtl/rss_ifs.sv @@
// ----------------------------------------------------------------------------
// rss_ifs: item channels of the RLE sprite span decoder
// rss_in_if carries stream bytes, remap loads and start commands; rss_out_if carries spans.
// ----------------------------------------------------------------------------
interface rss_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] byte_value;
  logic [7:0] remap_index;

  modport source (output valid, mode, byte_value, remap_index, input ready);
  modport sink (input valid, mode, byte_value, remap_index, output ready);
endinterface

interface rss_out_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   kind;
  logic signed [COORD_BITS-1:0] span_x;
  logic signed [COORD_BITS-1:0] span_y;
  logic [7:0]                   span_length;
  logic [7:0]                   color;

  modport source (output valid, kind, span_x, span_y, span_length, color, input ready);
  modport sink (input valid, kind, span_x, span_y, span_length, color, output ready);
endinterface

@@ hw/rtl/rle_sprite_span_decoder.sv @@
// ----------------------------------------------------------------------------
// rle_sprite_span_decoder: run-length sprite decoder with span clipping
// Parses the sprite byte stream, remaps colors and emits clipped spans.
// ----------------------------------------------------------------------------
// The decoder takes one item per clock cycle while the output is not
// stalled; an accepted byte passes through the stage 1 registers and the
// output register to its span. The first stage parses the byte against the
// parser registers and reads the 256-entry remap memory; the second stage
// clips the run, picks the color from the registered read data and loads
// the output register, which holds the span until it is taken. While the
// output is stalled the first stage holds its run, and once both are full
// the input stalls. Bytes that draw nothing or fall outside the clip window
// give no item. Remap loads write the memory at once and are seen by the
// next byte. The remap memory is not cleared by reset: load every entry
// that a sprite uses before turning on remapping. Configuration must be
// written only while no item is in flight; the block does not enforce it.
module rle_sprite_span_decoder #(
  parameter int COORD_BITS    = 12,
  parameter int REMAP_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  rss_in_if.sink                              bytes,
  rss_out_if.source                           spans,
  input  logic                                cfg_we,
  input  logic [rss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]               cfg_data
);

  localparam int C  = COORD_BITS;
  localparam int W  = COORD_BITS + 2;
  localparam int AW = $clog2(REMAP_ENTRIES);
  localparam logic [C-1:0] CMAX = {C{1'b1}};
  localparam logic [C-1:0] HALF = C'(1) << (C - 1);

  // Configuration registers
  logic signed [C-1:0] origin_x;
  logic signed [C-1:0] origin_y;
  logic [C-2:0]        clip_left;
  logic [C-1:0]        clip_right;
  logic [C-2:0]        clip_top;
  logic [C-1:0]        clip_bottom;
  logic                mirror;
  logic                remap_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      clip_left    <= '0;
      clip_right   <= C'(rss_pkg::CLIP_RIGHT_RESET);
      clip_top     <= '0;
      clip_bottom  <= C'(rss_pkg::CLIP_BOTTOM_RESET);
      mirror       <= 1'b0;
      remap_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (rss_pkg::reg_index_t'(cfg_index))
        rss_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data;
        rss_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data;
        rss_pkg::REG_CLIP_LEFT:    clip_left    <= cfg_data[C-2:0];
        rss_pkg::REG_CLIP_RIGHT:   clip_right   <= cfg_data;
        rss_pkg::REG_CLIP_TOP:     clip_top     <= cfg_data[C-2:0];
        rss_pkg::REG_CLIP_BOTTOM:  clip_bottom  <= cfg_data;
        rss_pkg::REG_MIRROR:       mirror       <= cfg_data[0];
        rss_pkg::REG_REMAP_ENABLE: remap_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake and stage control
  logic s1_valid;
  logic o_valid;
  logic o_free;
  logic accept;

  assign o_free      = !o_valid || spans.ready;
  assign bytes.ready = !s1_valid || o_free;
  assign accept      = bytes.valid && bytes.ready;

  // Remap memory, read and written at the accept edge
  logic [7:0] remap_mem [REMAP_ENTRIES];
  logic [7:0] mem_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      if (rss_pkg::mode_t'(bytes.mode) == rss_pkg::MODE_LOAD) begin
        remap_mem[bytes.remap_index[AW-1:0]] <= bytes.byte_value;
      end
      mem_q <= remap_mem[bytes.byte_value[AW-1:0]];
    end
  end

  // Parser state
  rss_pkg::phase_t phase, phase_next;
  logic [7:0]      run_rem, run_rem_next;
  logic [C-1:0]    col_off, col_off_next;
  logic [C-1:0]    row_off, row_off_next;
  logic            done, done_next;

  // Stage 1 decode
  logic [7:0]          b;
  logic                run_go;
  logic [7:0]          run_n;
  logic                run_shade;
  logic                run_remap;
  logic                end_go;
  logic                skip_go;
  logic [7:0]          add_amt;
  logic [C:0]          col_sum;
  logic [C-1:0]        col_sat;
  logic signed [W-1:0] ox_w, oy_w, y_w, off_w, n_w, bb_w, ctop_w;
  logic signed [W-1:0] lo_f, hi_f, ox_off, lo_m, hi_m;
  logic                draw_ok;

  assign b = bytes.byte_value;

  always_comb begin
    phase_next   = phase;
    run_rem_next = run_rem;
    done_next    = done;
    run_go       = 1'b0;
    run_n        = b;
    run_shade    = 1'b0;
    run_remap    = 1'b0;
    end_go       = 1'b0;
    skip_go      = 1'b0;
    if (!done) begin
      unique case (phase)
        rss_pkg::PH_LIT: begin
          run_rem_next = run_rem - 8'd1;
          if (run_rem_next == 8'd0) begin
            phase_next = rss_pkg::PH_CTRL;
          end
          run_go    = 1'b1;
          run_n     = 8'd1;
          run_remap = remap_enable;
        end
        rss_pkg::PH_SHA: begin
          if (b[1:0] == 2'd0) begin
            phase_next = rss_pkg::PH_SHB;
          end else begin
            phase_next = rss_pkg::PH_CTRL;
            run_go     = 1'b1;
            run_n      = {6'd0, b[1:0]};
            run_shade  = 1'b1;
          end
        end
        rss_pkg::PH_SHB: begin
          phase_next = rss_pkg::PH_CTRL;
          run_go     = 1'b1;
          run_shade  = 1'b1;
        end
        rss_pkg::PH_FCNT: begin
          run_rem_next = b;
          phase_next   = rss_pkg::PH_FVAL;
        end
        rss_pkg::PH_FVAL: begin
          phase_next   = rss_pkg::PH_CTRL;
          run_rem_next = 8'd0;
          run_go       = 1'b1;
          run_n        = run_rem;
          run_remap    = remap_enable;
        end
        rss_pkg::PH_CTRL: begin
          if (b == rss_pkg::CTRL_ROW_END) begin
            // Ends the sprite when the next row would reach the bottom bound.
            end_go = (y_w + W'(1)) >= bb_w;
          end else if (b < rss_pkg::CTRL_SPRITE_END) begin
            run_rem_next = b;
            phase_next   = rss_pkg::PH_LIT;
          end else if (b == rss_pkg::CTRL_SPRITE_END) begin
            end_go = 1'b1;
          end else if (b < rss_pkg::CTRL_SHADOW) begin
            skip_go = 1'b1;
          end else if (b == rss_pkg::CTRL_SHADOW) begin
            phase_next = rss_pkg::PH_SHA;
          end else if (b == rss_pkg::CTRL_FILL) begin
            phase_next = rss_pkg::PH_FCNT;
          end else begin
            run_rem_next = b - rss_pkg::CTRL_SHADOW;
            phase_next   = rss_pkg::PH_FVAL;
          end
        end
        default: ;
      endcase
      if (end_go) begin
        done_next    = 1'b1;
        phase_next   = rss_pkg::PH_CTRL;
        run_rem_next = 8'd0;
      end
    end
  end

  // Column advance saturates at the top of the offset range.
  assign add_amt = skip_go ? {1'b0, b[6:0]} : run_n;
  assign col_sum = {1'b0, col_off} + {{(C - 7){1'b0}}, add_amt};
  assign col_sat = col_sum[C] ? CMAX : col_sum[C-1:0];

  always_comb begin
    col_off_next = col_off;
    row_off_next = row_off;
    if (!done) begin
      if (run_go || skip_go) begin
        col_off_next = col_sat;
      end else if (phase == rss_pkg::PH_CTRL && b == rss_pkg::CTRL_ROW_END && !end_go) begin
        row_off_next = row_off + C'(1);
        col_off_next = '0;
      end
    end
  end

  assign ox_w   = {{2{origin_x[C-1]}}, origin_x};
  assign oy_w   = {{2{origin_y[C-1]}}, origin_y};
  assign off_w  = {2'b00, col_off};
  assign n_w    = {{(W - 8){1'b0}}, run_n};
  assign y_w    = oy_w + {2'b00, row_off};
  assign bb_w   = {2'b00, (clip_bottom > HALF) ? HALF : clip_bottom};
  assign ctop_w = {3'b000, clip_top};
  assign lo_f   = ox_w + off_w;
  assign hi_f   = lo_f + n_w;
  assign ox_off = ox_w - off_w;
  assign hi_m   = ox_off + W'(1);
  assign lo_m   = hi_m - n_w;

  assign draw_ok = (run_n != 8'd0) && (col_off != CMAX) && (y_w >= ctop_w) && (y_w < bb_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= rss_pkg::PH_CTRL;
      run_rem <= '0;
      col_off <= '0;
      row_off <= '0;
      done    <= 1'b1;
    end else if (accept) begin
      unique case (rss_pkg::mode_t'(bytes.mode))
        rss_pkg::MODE_STREAM: begin
          phase   <= phase_next;
          run_rem <= run_rem_next;
          col_off <= col_off_next;
          row_off <= row_off_next;
          done    <= done_next;
        end
        rss_pkg::MODE_START: begin
          phase   <= rss_pkg::PH_CTRL;
          run_rem <= '0;
          col_off <= '0;
          row_off <= '0;
          done    <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Stage 1 registers: the unclipped run or an end marker
  logic                s1_end;
  logic                s1_shade;
  logic                s1_remap;
  logic [7:0]          s1_color;
  logic signed [W-1:0] s1_lo, s1_hi, s1_y;
  logic                s1_cand;

  assign s1_cand = (rss_pkg::mode_t'(bytes.mode) == rss_pkg::MODE_STREAM) && !done
                   && (end_go || (run_go && draw_ok));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= s1_cand;
    end else if (o_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_end   <= end_go;
      s1_shade <= run_shade;
      s1_remap <= run_remap;
      s1_color <= run_shade ? 8'd0 : b;
      s1_lo    <= mirror ? lo_m : lo_f;
      s1_hi    <= mirror ? hi_m : hi_f;
      s1_y     <= y_w;
    end
  end

  // Stage 2: clip against the horizontal window
  logic signed [W-1:0] cl_w, br_w, lo_c, hi_c, len_w;
  logic                visible;

  assign cl_w    = {3'b000, clip_left};
  assign br_w    = {2'b00, (clip_right > HALF) ? HALF : clip_right};
  assign lo_c    = (s1_lo < cl_w) ? cl_w : s1_lo;
  assign hi_c    = (s1_hi > br_w) ? br_w : s1_hi;
  assign len_w   = hi_c - lo_c;
  assign visible = hi_c > lo_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_valid && o_free) begin
      o_valid <= s1_end || visible;
    end else if (spans.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && o_free) begin
      if (s1_end) begin
        spans.kind        <= rss_pkg::KIND_END;
        spans.span_x      <= '0;
        spans.span_y      <= '0;
        spans.span_length <= '0;
        spans.color       <= '0;
      end else begin
        spans.kind        <= s1_shade ? rss_pkg::KIND_SHADE : rss_pkg::KIND_SPAN;
        spans.span_x      <= lo_c[C-1:0];
        spans.span_y      <= s1_y[C-1:0];
        spans.span_length <= len_w[7:0];
        spans.color       <= s1_remap ? mem_q : s1_color;
      end
    end
  end

  assign spans.valid = o_valid;

endmodule
